// ----- design/bsm_pkg.sv -----
// shared types and constants of the byte stack machine core
`default_nettype none

package bsm_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_STEP  = 2'd3;

    localparam logic [2:0] RUN_IDLE   = 3'd0;
    localparam logic [2:0] RUN_ACTIVE = 3'd1;
    localparam logic [2:0] RUN_HALT   = 3'd2;
    localparam logic [2:0] RUN_PANIC  = 3'd3;
    localparam logic [2:0] RUN_UNIMPL = 3'd4;

    localparam logic [5:0] OP_PANIC = 6'd0;
    localparam logic [5:0] OP_HALT  = 6'd1;
    localparam logic [5:0] OP_LIT   = 6'd2;
    localparam logic [5:0] OP_DUP   = 6'd3;
    localparam logic [5:0] OP_DROP  = 6'd4;
    localparam logic [5:0] OP_UN5   = 6'd5;
    localparam logic [5:0] OP_UN6   = 6'd6;
    localparam logic [5:0] OP_ADD   = 6'd7;
    localparam logic [5:0] OP_SUB   = 6'd8;
    localparam logic [5:0] OP_JMP   = 6'd9;
    localparam logic [5:0] OP_JNEG  = 6'd10;
    localparam logic [5:0] OP_UN_LO = 6'd11;
    localparam logic [5:0] OP_UN_HI = 6'd16;
    localparam logic [5:0] OP_STORE = 6'd17;
    localparam logic [5:0] OP_LOAD  = 6'd18;

    localparam logic [15:0] START_RESET   = 16'h0100;
    localparam logic [15:0] CONSOLE_RESET = 16'h0012;

    localparam logic REG_START   = 1'b0;
    localparam logic REG_CONSOLE = 1'b1;

    typedef enum logic [1:0] {BASE_PC, BASE_SP, BASE_T, BASE_IN} base_sel_t;
    typedef enum logic [1:0] {DST_A, DST_B, DST_T, DST_INS} dst_t;
    typedef enum logic [2:0] {PC_HOLD, PC_INC, PC_ADDN, PC_T, PC_START} pc_op_t;
    typedef enum logic [2:0] {SP_HOLD, SP_ADDN, SP_SUBN, SP_ADD2, SP_ZERO} sp_op_t;

    typedef struct packed {
        logic      latch_in;
        logic      mem_we;
        logic      mem_re;
        logic      wsrc_in;
        base_sel_t base;
        logic [2:0] idx;
        dst_t      dst;
        pc_op_t    pc_op;
        sp_op_t    sp_op;
        logic      alu_en;
        logic      alu_sub;
        logic      set_console;
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] op;
        logic [1:0] size;
        logic       sign;
    } dp_sts_t;

endpackage

`default_nettype wire

// ----- design/bsm_datapath.sv -----
// datapath: byte memory, pc, sp, operand registers and adder/subtractor
`default_nettype none

module bsm_datapath
    import bsm_pkg::*;
#(
    parameter int MEM_BYTES = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire dp_cmd_t     cmd,
    input  wire logic [15:0] in_address,
    input  wire logic [7:0]  in_write_byte,
    input  wire logic [15:0] start_address,
    input  wire logic [15:0] console_address,
    output dp_sts_t          sts,
    output logic [15:0]      pc,
    output logic             console_valid,
    output logic [7:0]       console_byte,
    output logic [7:0]       low_byte
);

    localparam int AW = $clog2(MEM_BYTES);

    logic [7:0]  mem [MEM_BYTES];
    logic [7:0]  mem_q_reg;
    logic [15:0] pc_reg, pc_next;
    logic [15:0] sp_reg, sp_next;
    logic [63:0] a_reg, b_reg;
    logic [15:0] t_reg;
    logic [7:0]  ins_reg;
    logic [15:0] addr_reg;
    logic [7:0]  wbyte_reg;
    logic        cap_pend_reg;
    dst_t        cap_dst_reg;
    logic [2:0]  cap_idx_reg;
    logic        cvalid_reg;
    logic [7:0]  cbyte_reg;

    logic [15:0] base, addr, n16;
    logic [7:0]  wdata;
    logic [63:0] alu;

    assign n16 = 16'd1 << ins_reg[7:6];

    always_comb begin
        unique case (cmd.base)
            BASE_PC: base = pc_reg;
            BASE_SP: base = sp_reg;
            BASE_T:  base = t_reg;
            BASE_IN: base = addr_reg;
            default: base = addr_reg;
        endcase
        addr  = base + {13'd0, cmd.idx};
        wdata = cmd.wsrc_in ? wbyte_reg : a_reg[cmd.idx*8 +: 8];
        alu   = cmd.alu_sub ? (a_reg - b_reg) : (a_reg + b_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            mem[addr[AW-1:0]] <= wdata;
        end
        if (cmd.mem_re) begin
            mem_q_reg <= mem[addr[AW-1:0]];
        end
    end

    always_comb begin
        unique case (cmd.pc_op)
            PC_HOLD:  pc_next = pc_reg;
            PC_INC:   pc_next = pc_reg + 16'd1;
            PC_ADDN:  pc_next = pc_reg + n16;
            PC_T:     pc_next = t_reg;
            PC_START: pc_next = start_address;
            default:  pc_next = pc_reg;
        endcase
        unique case (cmd.sp_op)
            SP_HOLD: sp_next = sp_reg;
            SP_ADDN: sp_next = sp_reg + n16;
            SP_SUBN: sp_next = sp_reg - n16;
            SP_ADD2: sp_next = sp_reg + 16'd2;
            SP_ZERO: sp_next = 16'd0;
            default: sp_next = sp_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= START_RESET;
            sp_reg       <= 16'd0;
            cap_pend_reg <= 1'b0;
            cvalid_reg   <= 1'b0;
            cbyte_reg    <= 8'd0;
        end else begin
            pc_reg       <= pc_next;
            sp_reg       <= sp_next;
            cap_pend_reg <= cmd.mem_re;
            if (cmd.latch_in) begin
                cvalid_reg <= 1'b0;
                cbyte_reg  <= 8'd0;
            end else if (cmd.set_console && (t_reg == console_address)) begin
                cvalid_reg <= 1'b1;
                cbyte_reg  <= a_reg[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        cap_dst_reg <= cmd.dst;
        cap_idx_reg <= cmd.idx;
        if (cmd.latch_in) begin
            addr_reg  <= in_address;
            wbyte_reg <= in_write_byte;
        end
        if (cmd.alu_en) begin
            a_reg <= alu;
        end else if (cap_pend_reg && cap_dst_reg == DST_A) begin
            a_reg[cap_idx_reg*8 +: 8] <= mem_q_reg;
        end
        if (cap_pend_reg) begin
            unique case (cap_dst_reg)
                DST_A:   ;
                DST_B:   b_reg[cap_idx_reg*8 +: 8] <= mem_q_reg;
                DST_T:   t_reg[cap_idx_reg[0]*8 +: 8] <= mem_q_reg;
                DST_INS: ins_reg <= mem_q_reg;
                default: ;
            endcase
        end
    end

    always_comb begin
        sts.op   = ins_reg[5:0];
        sts.size = ins_reg[7:6];
        unique case (ins_reg[7:6])
            2'd0:    sts.sign = a_reg[7];
            2'd1:    sts.sign = a_reg[15];
            2'd2:    sts.sign = a_reg[31];
            default: sts.sign = a_reg[63];
        endcase
    end

    assign pc            = pc_reg;
    assign console_valid = cvalid_reg;
    assign console_byte  = cbyte_reg;
    assign low_byte      = a_reg[7:0];

endmodule

`default_nettype wire

// ----- design/bsm_ctrl.sv -----
// controller: command decode and instruction sequencer
`default_nettype none

module bsm_ctrl
    import bsm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_accept,
    input  wire logic [1:0] in_command,
    input  wire logic       out_busy,
    input  wire dp_sts_t    sts,
    output dp_cmd_t         cmd,
    output logic            in_ready,
    output logic            out_load,
    output logic            is_read,
    output logic [2:0]      run_state
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_WR    = 12'b0000_0000_0010,
        S_RD    = 12'b0000_0000_0100,
        S_RDW   = 12'b0000_0000_1000,
        S_FETCH = 12'b0000_0001_0000,
        S_FWAIT = 12'b0000_0010_0000,
        S_DEC   = 12'b0000_0100_0000,
        S_LD    = 12'b0000_1000_0000,
        S_LDW   = 12'b0001_0000_0000,
        S_EXEC  = 12'b0010_0000_0000,
        S_ST    = 12'b0100_0000_0000,
        S_RESP  = 12'b1000_0000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic       ph_reg, ph_next;
    logic [2:0] idx_reg, idx_next;
    logic [2:0] run_reg, run_next;
    logic       read_reg, read_next;
    logic [2:0] nlast, ld_last;
    logic [5:0] op;

    assign op = sts.op;

    always_comb begin
        unique case (sts.size)
            2'd0:    nlast = 3'd0;
            2'd1:    nlast = 3'd1;
            2'd2:    nlast = 3'd3;
            default: nlast = 3'd7;
        endcase
        ld_last = nlast;
        if (!ph_reg && (op == OP_JMP || op == OP_JNEG || op == OP_STORE || op == OP_LOAD)) begin
            ld_last = 3'd1;
        end
    end

    always_comb begin
        cmd        = '0;
        cmd.base   = BASE_SP;
        cmd.dst    = DST_A;
        cmd.pc_op  = PC_HOLD;
        cmd.sp_op  = SP_HOLD;
        cmd.idx    = idx_reg;
        state_next = state_reg;
        ph_next    = ph_reg;
        idx_next   = idx_reg;
        run_next   = run_reg;
        read_next  = read_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    cmd.latch_in = 1'b1;
                    read_next    = (in_command == CMD_READ);
                    unique case (in_command)
                        CMD_WRITE: state_next = S_WR;
                        CMD_READ:  state_next = S_RD;
                        CMD_START: begin
                            cmd.pc_op  = PC_START;
                            cmd.sp_op  = SP_ZERO;
                            run_next   = RUN_ACTIVE;
                            state_next = S_RESP;
                        end
                        default: state_next = (run_reg == RUN_ACTIVE) ? S_FETCH : S_RESP;
                    endcase
                end
            end
            S_WR: begin
                cmd.base    = BASE_IN;
                cmd.idx     = 3'd0;
                cmd.mem_we  = 1'b1;
                cmd.wsrc_in = 1'b1;
                state_next  = S_RESP;
            end
            S_RD: begin
                cmd.base   = BASE_IN;
                cmd.idx    = 3'd0;
                cmd.mem_re = 1'b1;
                state_next = S_RDW;
            end
            S_RDW: state_next = S_RESP;
            S_FETCH: begin
                cmd.base   = BASE_PC;
                cmd.idx    = 3'd0;
                cmd.dst    = DST_INS;
                cmd.mem_re = 1'b1;
                state_next = S_FWAIT;
            end
            S_FWAIT: state_next = S_DEC;
            S_DEC: begin
                cmd.pc_op  = PC_INC;
                ph_next    = 1'b0;
                idx_next   = 3'd0;
                state_next = S_RESP;
                if (op == OP_PANIC) begin
                    run_next = RUN_PANIC;
                end else if (op == OP_HALT) begin
                    run_next = RUN_HALT;
                end else if (op == OP_DROP) begin
                    cmd.sp_op = SP_ADDN;
                end else if (op == OP_UN5 || op == OP_UN6 ||
                             (op >= OP_UN_LO && op <= OP_UN_HI)) begin
                    run_next = RUN_UNIMPL;
                end else if (op == OP_LIT || op == OP_DUP || op == OP_ADD || op == OP_SUB ||
                             op == OP_JMP || op == OP_JNEG || op == OP_STORE ||
                             op == OP_LOAD) begin
                    state_next = S_LD;
                end
            end
            S_LD: begin
                cmd.mem_re = 1'b1;
                if (op == OP_LIT) begin
                    cmd.base = BASE_PC;
                end else if (op == OP_LOAD && ph_reg) begin
                    cmd.base = BASE_T;
                end
                if (!ph_reg && (op == OP_ADD || op == OP_SUB)) begin
                    cmd.dst = DST_B;
                end else if (!ph_reg && (op == OP_JMP || op == OP_JNEG ||
                                         op == OP_STORE || op == OP_LOAD)) begin
                    cmd.dst = DST_T;
                end
                if (idx_reg == ld_last) begin
                    idx_next   = 3'd0;
                    state_next = S_LDW;
                end else begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            S_LDW: begin
                state_next = S_RESP;
                if (op == OP_LIT) begin
                    cmd.sp_op  = SP_SUBN;
                    cmd.pc_op  = PC_ADDN;
                    state_next = S_ST;
                end else if (op == OP_DUP) begin
                    cmd.sp_op  = SP_SUBN;
                    state_next = S_ST;
                end else if (op == OP_ADD || op == OP_SUB) begin
                    cmd.sp_op  = SP_ADDN;
                    ph_next    = 1'b1;
                    state_next = ph_reg ? S_EXEC : S_LD;
                end else if (!ph_reg) begin
                    cmd.sp_op  = SP_ADD2;
                    ph_next    = 1'b1;
                    state_next = (op == OP_JMP) ? S_EXEC : S_LD;
                end else if (op == OP_JNEG) begin
                    cmd.sp_op  = SP_ADDN;
                    state_next = S_EXEC;
                end else if (op == OP_STORE) begin
                    state_next = S_ST;
                end else begin
                    cmd.sp_op  = SP_SUBN;
                    state_next = S_ST;
                end
            end
            S_EXEC: begin
                state_next = S_RESP;
                if (op == OP_ADD || op == OP_SUB) begin
                    cmd.alu_en  = 1'b1;
                    cmd.alu_sub = (op == OP_SUB);
                    cmd.sp_op   = SP_SUBN;
                    state_next  = S_ST;
                end else if (op == OP_JMP || sts.sign) begin
                    cmd.pc_op = PC_T;
                end
            end
            S_ST: begin
                cmd.mem_we = 1'b1;
                cmd.base   = (op == OP_STORE) ? BASE_T : BASE_SP;
                if (idx_reg == nlast) begin
                    idx_next   = 3'd0;
                    state_next = S_RESP;
                    if (op == OP_STORE) begin
                        cmd.sp_op       = SP_ADDN;
                        cmd.set_console = 1'b1;
                    end
                end else begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            S_RESP: begin
                if (!out_busy) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ph_reg    <= 1'b0;
            idx_reg   <= 3'd0;
            run_reg   <= RUN_IDLE;
            read_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            idx_reg   <= idx_next;
            run_reg   <= run_next;
            read_reg  <= read_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign is_read   = read_reg;
    assign run_state = run_reg;

endmodule

`default_nettype wire

// ----- design/byte_stack_machine_core.sv -----
// top level of the byte stack machine core: register port, result register, checks
//
// usage:
//   s_ channel carries one command beat: write byte, read byte, start, or step
//   one instruction. each command gives exactly one m_ beat with status, pc,
//   console output and read data. pready is always high.
//   registers start_address (0x0) and console_address (0x4) are written over the
//   apb port, by the user only while the core is idle; the core does not check it.
// sequencing:
//   write stores the byte, read fetches it from memory; an executed step fetches
//   and decodes the instruction, moves each operand byte through the single-port
//   byte memory in its load phases, runs an add, subtract or branch stage where
//   needed and stores its result bytes. one command is in flight at a time.
// stalls:
//   the result register holds a beat while m_ready is low; a new command is
//   taken meanwhile and its work proceeds until its own result is ready.
// reset:
//   synchronous active-low aresetn: pc 0x100, sp 0, status idle, registers to
//   their defaults; memory contents are undefined until written.
`default_nettype none

module byte_stack_machine_core
    import bsm_pkg::*;
#(
    parameter int MEM_BYTES = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [15:0] s_address,
    input  wire logic [7:0]  s_write_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic             m_console_valid,
    output logic [7:0]       m_console_byte,
    output logic [15:0]      m_program_counter,
    output logic [7:0]       m_read_byte,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [15:0] start_reg, console_reg;
    logic        m_valid_reg;
    logic [2:0]  status_reg;
    logic        cvalid_reg;
    logic [7:0]  cbyte_reg, rbyte_reg;
    logic [15:0] pc_out_reg;

    dp_cmd_t     cmd;
    dp_sts_t     sts;
    logic        in_accept, out_busy, out_load, is_read;
    logic [2:0]  run_state;
    logic [15:0] dp_pc;
    logic        dp_cvalid;
    logic [7:0]  dp_cbyte, dp_low;

    assign pready    = 1'b1;
    assign in_accept = s_valid && s_ready;
    assign out_busy  = m_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg   <= START_RESET;
            console_reg <= CONSOLE_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_START) begin
                start_reg <= pwdata[15:0];
            end else begin
                console_reg <= pwdata[15:0];
            end
        end
    end

    assign prdata = {16'd0, (paddr[2] == REG_CONSOLE) ? console_reg : start_reg};

    bsm_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .in_command (s_command),
        .out_busy   (out_busy),
        .sts        (sts),
        .cmd        (cmd),
        .in_ready   (s_ready),
        .out_load   (out_load),
        .is_read    (is_read),
        .run_state  (run_state)
    );

    bsm_datapath #(
        .MEM_BYTES (MEM_BYTES)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .in_address      (s_address),
        .in_write_byte   (s_write_byte),
        .start_address   (start_reg),
        .console_address (console_reg),
        .sts             (sts),
        .pc              (dp_pc),
        .console_valid   (dp_cvalid),
        .console_byte    (dp_cbyte),
        .low_byte        (dp_low)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            status_reg <= run_state;
            cvalid_reg <= dp_cvalid;
            cbyte_reg  <= dp_cbyte;
            pc_out_reg <= dp_pc;
            rbyte_reg  <= is_read ? dp_low : 8'd0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = status_reg;
    assign m_console_valid   = cvalid_reg;
    assign m_console_byte    = cbyte_reg;
    assign m_program_counter = pc_out_reg;
    assign m_read_byte       = rbyte_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !out_busy)
        else $error("result register overwritten while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_ready)
        else $error("second command taken while one is in flight");

    a_console_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_console_valid) |-> (m_status == RUN_ACTIVE))
        else $error("console beat from a stopped machine");

    a_read_only_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !is_read) |=> (m_read_byte == 8'd0))
        else $error("read data on a non-read result");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// self-checking testbench for byte_stack_machine_core: predicted results, random programs
`default_nettype none

module testbench;
    import bsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [5:0] OP_NOP_LO = 6'd19;
    localparam logic [5:0] OP_NOP_HI = 6'd63;

    localparam int ROLE_CODE   = 0;
    localparam int ROLE_TARGET = 1;
    localparam int ROLE_DATA   = 2;

    localparam int ITEM_COUNT  = 1950;
    localparam int PHASES      = 5;
    localparam int DRAIN_WAIT  = 40;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [2:0]  status;
        logic        console_valid;
        logic [7:0]  console_byte;
        logic [15:0] program_counter;
        logic [7:0]  read_byte;
    } beat_t;

    class bsm_scoreboard;
        logic [7:0]  mem [65536];
        bit          known [65536];
        logic [15:0] seen [$];
        logic [15:0] pc = START_RESET;
        logic [15:0] sp = '0;
        logic [2:0]  run = RUN_IDLE;
        logic [15:0] start_addr = START_RESET;
        logic [15:0] console_addr = CONSOLE_RESET;
        beat_t       expected_beats [$];
        int          errors = 0;
        int          executed = 0;
        int          console_hits = 0;

        function void put(logic [15:0] a, logic [7:0] b);
            if (!known[a]) seen.push_back(a);
            known[a] = 1'b1;
            mem[a] = b;
        endfunction

        function logic [63:0] load_le(logic [15:0] a, int n);
            logic [63:0] v;
            v = '0;
            for (int k = 0; k < n; k++) v |= 64'(mem[16'(a + k)]) << (8 * k);
            return v;
        endfunction

        function void store_le(logic [15:0] a, int n, logic [63:0] v);
            for (int k = 0; k < n; k++) put(16'(a + k), 8'(v >> (8 * k)));
        endfunction

        function logic [63:0] pop(int n);
            logic [15:0] old;
            old = sp;
            sp = 16'(sp + n);
            return load_le(old, n);
        endfunction

        function void push(int n, logic [63:0] v);
            sp = 16'(sp - n);
            store_le(sp, n, v);
        endfunction

        function bit span_gap(logic [15:0] a, int len, output logic [15:0] g);
            for (int k = 0; k < len; k++) begin
                if (!known[16'(a + k)]) begin
                    g = 16'(a + k);
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // first byte the next step would read that was never written
        function bit find_gap(output logic [15:0] g, output int role);
            logic [7:0]  ins;
            logic [15:0] t;
            int          n;
            role = ROLE_DATA;
            g = '0;
            if (run != RUN_ACTIVE) return 1'b0;
            if (!known[pc]) begin
                g = pc;
                role = ROLE_CODE;
                return 1'b1;
            end
            ins = mem[pc];
            n = 1 << ins[7:6];
            case (ins[5:0])
                OP_LIT:          return span_gap(16'(pc + 1), n, g);
                OP_DUP:          return span_gap(sp, n, g);
                OP_ADD, OP_SUB:  return span_gap(sp, 2 * n, g);
                OP_JMP:          return span_gap(sp, 2, g);
                OP_JNEG:         return span_gap(sp, 2 + n, g);
                OP_STORE: begin
                    if (span_gap(sp, 2, g)) begin
                        role = ROLE_TARGET;
                        return 1'b1;
                    end
                    return span_gap(16'(sp + 2), n, g);
                end
                OP_LOAD: begin
                    if (span_gap(sp, 2, g)) return 1'b1;
                    t = 16'(load_le(sp, 2));
                    return span_gap(t, n, g);
                end
                default: return 1'b0;
            endcase
        endfunction

        function void note_command(logic [1:0] cmd, logic [15:0] a, logic [7:0] wb);
            beat_t       r;
            logic [7:0]  ins;
            logic [63:0] x, y;
            logic [15:0] t;
            int          n;
            r = '0;
            case (cmd)
                CMD_WRITE: put(a, wb);
                CMD_READ:  r.read_byte = mem[a];
                CMD_START: begin
                    pc = start_addr;
                    sp = '0;
                    run = RUN_ACTIVE;
                end
                default: begin
                    if (run == RUN_ACTIVE) begin
                        executed++;
                        ins = mem[pc];
                        n = 1 << ins[7:6];
                        pc = 16'(pc + 1);
                        case (ins[5:0])
                            OP_PANIC: run = RUN_PANIC;
                            OP_HALT:  run = RUN_HALT;
                            OP_LIT: begin
                                x = load_le(pc, n);
                                push(n, x);
                                pc = 16'(pc + n);
                            end
                            OP_DUP: begin
                                x = load_le(sp, n);
                                push(n, x);
                            end
                            OP_DROP: sp = 16'(sp + n);
                            OP_ADD: begin
                                y = pop(n);
                                x = pop(n);
                                push(n, x + y);
                            end
                            OP_SUB: begin
                                y = pop(n);
                                x = pop(n);
                                push(n, x - y);
                            end
                            OP_JMP: pc = 16'(pop(2));
                            OP_JNEG: begin
                                t = 16'(pop(2));
                                x = pop(n);
                                if (x[8 * n - 1]) pc = t;
                            end
                            OP_STORE: begin
                                t = 16'(pop(2));
                                x = load_le(sp, n);
                                store_le(t, n, x);
                                sp = 16'(sp + n);
                                if (t == console_addr) begin
                                    r.console_valid = 1'b1;
                                    r.console_byte = mem[t];
                                    console_hits++;
                                end
                            end
                            OP_LOAD: begin
                                t = 16'(pop(2));
                                push(n, load_le(t, n));
                            end
                            OP_UN5, OP_UN6: run = RUN_UNIMPL;
                            default: begin
                                if (ins[5:0] >= OP_UN_LO && ins[5:0] <= OP_UN_HI)
                                    run = RUN_UNIMPL;
                            end
                        endcase
                    end
                end
            endcase
            r.status = run;
            r.program_counter = pc;
            expected_beats.push_back(r);
        endfunction

        function void check_beat(beat_t got);
            beat_t e;
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            e = expected_beats.pop_front();
            if (got.status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, got.status);
                errors++;
            end
            if (got.console_valid !== e.console_valid) begin
                $error("console_valid: expected %0d, got %0d", e.console_valid,
                       got.console_valid);
                errors++;
            end
            if (got.console_byte !== e.console_byte) begin
                $error("console_byte: expected %h, got %h", e.console_byte, got.console_byte);
                errors++;
            end
            if (got.program_counter !== e.program_counter) begin
                $error("program_counter: expected %h, got %h", e.program_counter,
                       got.program_counter);
                errors++;
            end
            if (got.read_byte !== e.read_byte) begin
                $error("read_byte: expected %h, got %h", e.read_byte, got.read_byte);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = CMD_WRITE;
    logic [15:0] s_address = '0;
    logic [7:0]  s_write_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic        m_console_valid;
    logic [7:0]  m_console_byte;
    logic [15:0] m_program_counter;
    logic [7:0]  m_read_byte;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bsm_scoreboard sb = new();
    bit quiet = 1'b0;
    int items_sent = 0;
    int ready_hold = 0;
    int watchdog = 0;

    byte_stack_machine_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_address(s_address), .s_write_byte(s_write_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_console_valid(m_console_valid), .m_console_byte(m_console_byte),
        .m_program_counter(m_program_counter), .m_read_byte(m_read_byte),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
            ready_hold <= $urandom_range(0, 10);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (m_valid && m_ready)
            sb.check_beat({m_status, m_console_valid, m_console_byte,
                           m_program_counter, m_read_byte});
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            watchdog <= 0;
        end else if (watchdog >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            watchdog <= watchdog + 1;
        end
    end

    task automatic send(logic [1:0] cmd, logic [15:0] a, logic [7:0] wb);
        s_valid <= 1'b1;
        s_command <= cmd;
        s_address <= a;
        s_write_byte <= wb;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_command(cmd, a, wb);
        items_sent++;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    task automatic reg_write(logic regsel, logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {regsel, 2'b00};
        pwdata <= {16'h0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (regsel == REG_START) sb.start_addr = value;
        else sb.console_addr = value;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    function automatic logic [7:0] make_ins();
        logic [5:0] op;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 2) op = OP_PANIC;
        else if (pick < 4) op = OP_HALT;
        else if (pick < 6) op = 6'($urandom_range(OP_UN_LO, OP_UN_HI));
        else if (pick < 7) op = $urandom_range(0, 1) ? OP_UN5 : OP_UN6;
        else if (pick < 11) op = 6'($urandom_range(OP_NOP_LO, OP_NOP_HI));
        else if (pick < 35) op = OP_LIT;
        else if (pick < 44) op = OP_DUP;
        else if (pick < 50) op = OP_DROP;
        else if (pick < 59) op = OP_ADD;
        else if (pick < 67) op = OP_SUB;
        else if (pick < 72) op = OP_JMP;
        else if (pick < 80) op = OP_JNEG;
        else if (pick < 91) op = OP_STORE;
        else op = OP_LOAD;
        return {2'($urandom_range(0, 3)), op};
    endfunction

    // writes every never-written byte the next instruction needs, then steps it
    task automatic step_once();
        logic [15:0] g;
        logic [7:0]  b;
        int          role;
        while (sb.find_gap(g, role)) begin
            if (role == ROLE_CODE) b = make_ins();
            else if (role == ROLE_TARGET && $urandom_range(0, 1))
                b = (g == sb.sp) ? sb.console_addr[7:0] : sb.console_addr[15:8];
            else b = 8'($urandom);
            send(CMD_WRITE, g, b);
        end
        send(CMD_STEP, 16'($urandom), 8'($urandom));
    endtask

    initial begin
        logic [5:0] ops [17];
        logic [15:0] a;
        int pick;
        ops = '{OP_LIT, OP_DUP, OP_DROP, OP_ADD, OP_SUB, OP_STORE, OP_LOAD, OP_JNEG,
                OP_JMP, OP_NOP_LO, OP_NOP_HI, OP_PANIC, OP_HALT, OP_UN5, OP_UN6,
                OP_UN_LO, OP_UN_HI};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, idle step, each opcode kind from a wrapping start address
        reg_write(REG_START, 16'hffff);
        reg_write(REG_CONSOLE, 16'h0000);
        send(CMD_WRITE, 16'hffff, 8'hff);
        send(CMD_WRITE, 16'h0000, 8'h00);
        send(CMD_READ, 16'hffff, 8'h00);
        send(CMD_READ, 16'h0000, 8'hff);
        send(CMD_STEP, 16'h0000, 8'h00);
        foreach (ops[i]) begin
            if (sb.run != RUN_ACTIVE) send(CMD_START, 16'hffff, 8'hff);
            send(CMD_WRITE, sb.pc, {2'($urandom_range(0, 3)), ops[i]});
            step_once();
        end
        send(CMD_STEP, 16'h5555, 8'haa);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            quiet = (ph == PHASES - 1);
            case (ph)
                0: begin
                    reg_write(REG_START, 16'h0000);
                    reg_write(REG_CONSOLE, 16'hffff);
                end
                1: begin
                    reg_write(REG_START, START_RESET);
                    reg_write(REG_CONSOLE, CONSOLE_RESET);
                end
                default: begin
                    reg_write(REG_START, 16'($urandom));
                    reg_write(REG_CONSOLE, 16'($urandom));
                end
            endcase
            while (items_sent < (ph + 1) * ITEM_COUNT / PHASES) begin
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    send(CMD_WRITE, 16'($urandom), 8'($urandom));
                end else if (pick < 12) begin
                    a = sb.seen[$urandom_range(0, sb.seen.size() - 1)];
                    send(CMD_READ, a, 8'($urandom));
                end else if (pick < 14 || (sb.run != RUN_ACTIVE && pick < 80)) begin
                    send(CMD_START, 16'($urandom), 8'($urandom));
                end else begin
                    step_once();
                end
            end
        end

        drain();
        $display("executed %0d instructions over %0d commands, %0d console bytes",
                 sb.executed, items_sent, sb.console_hits);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
